### src/bmm_pkg.sv
// Package for the bipartite matching block: shared widths, action codes and register addresses.
// No dependencies.
package bmm_pkg;
  localparam int unsigned CntW = 6;
  localparam int unsigned IdxW = 5;
  localparam logic [0:0] ActAdd = 1'b0;
  localparam logic [0:0] ActCompute = 1'b1;
  localparam logic [1:0] RegNumLeft = 2'd0;
  localparam logic [1:0] RegNumRight = 2'd1;
endpackage

### src/bmm_edge_mem.sv
// Edge row memory for the matching block: one row of right-vertex bits per left vertex.
// Registered synchronous read; depends on nothing else.
module bmm_edge_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/bipartite_max_matching.sv
// Bipartite maximum matching by repeated breadth-first augmenting-path searches.
// Add-edge transfer: the row is read, then written back the next cycle; the next add waits for
// the write. Compute: one search per augmenting path plus a last failing one. Each search seeds
// the queue with the unmatched left vertices, reads the row of each dequeued left vertex and
// visits each right vertex reached, then flips the pairs on the path found; the result waits
// until it is taken. After it, and after reset, the edge rows are swept clear one per cycle.
module bipartite_max_matching #(
  parameter int unsigned MAX_LEFT  = 32,
  parameter int unsigned MAX_RIGHT = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [bmm_pkg::IdxW-1:0]   left_index_i,
  input  logic [bmm_pkg::IdxW-1:0]   right_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bmm_pkg::CntW-1:0]   matching_size_o
);
  localparam int unsigned LW = (MAX_LEFT > 1) ? $clog2(MAX_LEFT) : 1;
  localparam int unsigned RW = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
  localparam int unsigned LC = $clog2(MAX_LEFT + 1);
  localparam int unsigned RC = $clog2(MAX_RIGHT + 1);

  // Sequencer states. The input is only taken in StIdle; the result is offered in StOut.
  localparam logic [3:0] StClr   = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StAddWr = 4'd2;
  localparam logic [3:0] StInit  = 4'd3;
  localparam logic [3:0] StPop   = 4'd4;
  localparam logic [3:0] StScan  = 4'd5;
  localparam logic [3:0] StVisit = 4'd6;
  localparam logic [3:0] StWalk  = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  // Configuration registers, clamped for use below.
  logic [bmm_pkg::CntW-1:0] num_left_q, num_right_q;
  logic [LC-1:0] nl;
  logic [RC-1:0] nr;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_left_q  <= 6'd32;
      num_right_q <= 6'd32;
    end else if (psel && penable && pwrite) begin
      if (paddr[2:2] == bmm_pkg::RegNumLeft[0:0] && paddr[1:0] == 2'd0) begin
        num_left_q <= pwdata[5:0];
      end else if (paddr[2:2] == bmm_pkg::RegNumRight[0:0] && paddr[1:0] == 2'd0) begin
        num_right_q <= pwdata[5:0];
      end
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      if (paddr[2:2] == bmm_pkg::RegNumLeft[0:0]) prdata[5:0] = num_left_q;
      else prdata[5:0] = num_right_q;
    end
  end
  assign nl = (32'(num_left_q) > MAX_LEFT) ? LC'(MAX_LEFT) : LC'(num_left_q);
  assign nr = (32'(num_right_q) > MAX_RIGHT) ? RC'(MAX_RIGHT) : RC'(num_right_q);

  logic [MAX_RIGHT-1:0] rmask;
  always_comb begin
    for (int i = 0; i < MAX_RIGHT; i++) rmask[i] = (i < 32'(nr));
  end

  // Control and search state.
  logic [3:0]               st_q, st_d;
  logic [LW-1:0]            cnt_q, cnt_d;
  logic [MAX_LEFT-1:0]      lmatch_q, lmatch_d;
  logic [MAX_RIGHT-1:0]     rvalid_q, rvalid_d;
  logic [LC-1:0]            head_q, head_d, tail_q, tail_d;
  logic [MAX_RIGHT-1:0]     seen_q, seen_d;
  logic [MAX_RIGHT-1:0]     row_q, row_d;
  logic [LW-1:0]            cur_q, cur_d;
  logic [RW-1:0]            fr_q, fr_d;
  logic [bmm_pkg::CntW-1:0] size_q, size_d;
  logic [bmm_pkg::IdxW-1:0] li_q, ri_q;

  // Search scratch. Every entry is written in the current compute before it is read.
  logic [LW-1:0] rpart_q [MAX_RIGHT];
  logic [LW-1:0] sparent_q [MAX_RIGHT];
  logic [RW-1:0] lvia_q [MAX_LEFT];
  logic [LW-1:0] queue_q [MAX_LEFT];

  // Edge memory port.
  logic                 m_we;
  logic [LW-1:0]        m_waddr, m_raddr;
  logic [MAX_RIGHT-1:0] m_wdata, m_rdata;
  bmm_edge_mem #(.Depth(MAX_LEFT), .Width(MAX_RIGHT)) u_mem (
    .clk_i(clk_i), .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  // Lowest set bit of the remaining row.
  logic          any_r;
  logic [RW-1:0] low_r;
  always_comb begin
    any_r = 1'b0;
    low_r = '0;
    for (int i = MAX_RIGHT - 1; i >= 0; i--) begin
      if (row_q[i]) begin
        any_r = 1'b1;
        low_r = RW'(i);
      end
    end
  end

  logic          q_we, sp_we, lv_we, rp_we;
  logic [LW-1:0] q_waddr, q_wdata;

  // During the path walk, pl is the left vertex that reached the current right vertex and
  // nxt_r the right vertex through which pl itself was reached.
  logic [LW-1:0] pl;
  logic [RW-1:0] nxt_r;
  assign pl    = sparent_q[fr_q];
  assign nxt_r = lvia_q[pl];

  assign in_stall_o      = (st_q != StIdle);
  assign out_valid_o     = (st_q == StOut);
  assign matching_size_o = size_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; lmatch_d = lmatch_q; rvalid_d = rvalid_q;
    head_d = head_q; tail_d = tail_q; seen_d = seen_q; row_d = row_q;
    cur_d = cur_q; fr_d = fr_q; size_d = size_q;
    m_we = 1'b0; m_waddr = cnt_q; m_wdata = '0; m_raddr = cur_q;
    q_we = 1'b0; q_waddr = tail_q[LW-1:0]; q_wdata = cnt_q;
    sp_we = 1'b0; lv_we = 1'b0; rp_we = 1'b0;
    case (st_q)
      StClr: begin
        m_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == MAX_LEFT - 1) begin
          cnt_d = '0;
          st_d = StIdle;
        end
      end
      StIdle: begin
        // The row of an add is read at the accepting edge and arrives in StAddWr.
        m_raddr = LW'(left_index_i);
        if (in_valid_i) begin
          if (action_i == bmm_pkg::ActAdd) begin
            st_d = StAddWr;
          end else begin
            lmatch_d = '0; rvalid_d = '0; size_d = '0;
            cnt_d = '0; tail_d = '0; head_d = '0; seen_d = '0;
            st_d = StInit;
          end
        end
      end
      StAddWr: begin
        // Edges outside the current counts are dropped.
        if (32'(li_q) < 32'(nl) && 32'(ri_q) < 32'(nr)) begin
          m_we = 1'b1;
          m_waddr = LW'(li_q);
          m_wdata = m_rdata | (MAX_RIGHT'(1) << ri_q);
        end
        st_d = StIdle;
      end
      StInit: begin
        // Queue every unmatched left vertex in use, one per cycle.
        if (32'(cnt_q) < 32'(nl) && !lmatch_q[cnt_q]) begin
          q_we = 1'b1;
          tail_d = tail_q + 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) + 1 >= 32'(nl) || 32'(cnt_q) >= MAX_LEFT - 1) st_d = StPop;
      end
      StPop: begin
        // An empty queue means no augmenting path is left and the matching is maximum.
        if (head_q == tail_q) begin
          st_d = StOut;
        end else begin
          cur_d = queue_q[head_q[LW-1:0]];
          m_raddr = queue_q[head_q[LW-1:0]];
          head_d = head_q + 1'b1;
          st_d = StScan;
        end
      end
      StScan: begin
        row_d = m_rdata & rmask & ~seen_q;
        st_d = StVisit;
      end
      StVisit: begin
        // One right vertex of the row per cycle, lowest index first.
        if (!any_r) begin
          st_d = StPop;
        end else begin
          seen_d[low_r] = 1'b1;
          row_d[low_r] = 1'b0;
          sp_we = 1'b1;
          if (!rvalid_q[low_r]) begin
            fr_d = low_r;
            st_d = StWalk;
          end else if (32'(tail_q) < MAX_LEFT) begin
            lv_we = 1'b1;
            q_we = 1'b1;
            q_wdata = rpart_q[low_r];
            tail_d = tail_q + 1'b1;
          end
        end
      end
      StWalk: begin
        // Flip one pair of the path per cycle until the free left vertex is reached.
        rp_we = 1'b1;
        rvalid_d[fr_q] = 1'b1;
        lmatch_d[pl] = 1'b1;
        if (!lmatch_q[pl]) begin
          size_d = size_q + 1'b1;
          cnt_d = '0; tail_d = '0; head_d = '0; seen_d = '0;
          st_d = StInit;
        end else begin
          fr_d = nxt_r;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          cnt_d = '0;
          st_d = StClr;
        end
      end
      default: begin
        cnt_d = '0;
        st_d = StClr;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_valid_i) begin
      li_q <= left_index_i;
      ri_q <= right_index_i;
    end
    if (q_we) queue_q[q_waddr] <= q_wdata;
    if (sp_we) sparent_q[low_r] <= cur_q;
    if (lv_we) lvia_q[rpart_q[low_r]] <= low_r;
    if (rp_we) rpart_q[fr_q] <= pl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; cnt_q <= '0; lmatch_q <= '0; rvalid_q <= '0;
      head_q <= '0; tail_q <= '0; seen_q <= '0; row_q <= '0;
      cur_q <= '0; fr_q <= '0; size_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; lmatch_q <= lmatch_d; rvalid_q <= rvalid_d;
      head_q <= head_d; tail_q <= tail_d; seen_q <= seen_d; row_q <= row_d;
      cur_q <= cur_d; fr_q <= fr_d; size_q <= size_d;
    end
  end
endmodule
